FILE: rtl/core/mq3s_pkg.sv
// Package for the median-of-three quicksort block.
// Holds payload structs, FSM state type and controller/datapath command types.
package mq3s_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POP_W,
    ST_RANGE,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_MID,
    ST_PIVOT,
    ST_SCAN_L,
    ST_SCAN_LW,
    ST_SCAN_R,
    ST_SCAN_RW,
    ST_SWAP_W,
    ST_SWAP_W2,
    ST_PART_END,
    ST_PAIR_RD,
    ST_PAIR_W,
    ST_PAIR_LO,
    ST_PAIR_LO1,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // Memory address select.
  typedef enum logic [3:0] {
    A_LO, A_HI1, A_MID, A_LC, A_RC, A_LO1, A_EMIT, A_LC1, A_RC1
  } addr_sel_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic      store_in;    // write input value at count
    logic      clr_count;
    logic      init_stack;  // sp <= 0, push (0,count)
    logic      pop;         // read top of stack into lo/hi
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      cap_a;
    logic      cap_b;
    logic      cap_c;
    logic      set_pivot;   // pivot <= med3(a,b,c), cursors reset
    logic      inc_lc;
    logic      dec_rc;
    logic      wr_lc_b;     // mem[lc] <= b (value at rc)
    logic      wr_rc_a;     // mem[rc] <= a (value at lc)
    logic      swap_adv;    // lc++, rc--
    logic      part_end;    // push (lo, rc+1), lo <= lc
    logic      pair_wr_lo;  // mem[lo] <= b
    logic      pair_wr_lo1; // mem[lo+1] <= a
    logic      emit_clr;
    logic      emit_inc;
    logic      out_load;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic full;
    logic count_zero;
    logic stack_empty;
    logic range_small;  // hi - lo <= 2
    logic range_two;    // hi - lo == 2
    logic range_done;   // hi <= lo
    logic scan_l_go;    // lc < hi-1 && mem[lc] < pivot (with rdata in a)
    logic scan_r_go;
    logic cross_ok;     // lc <= rc
    logic pair_swap;    // a > b
    logic emit_last;
  } stat_t;

endpackage

FILE: rtl/core/mq3s_datapath.sv
// Datapath of the quicksort block: element store, range stack, cursors, pivot.
// Depends on mq3s_pkg.
module mq3s_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  mq3s_pkg::cmd_t     cmd,
  input  logic signed [31:0] in_value,
  output mq3s_pkg::stat_t    stat,
  output logic signed [31:0] out_value
);
  import mq3s_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

  logic signed [31:0] mem [MAX_ITEMS];
  logic signed [31:0] rdata;
  logic [2*CW-1:0]    stk [MAX_ITEMS];
  logic [2*CW-1:0]    stk_rd;

  logic [CW-1:0] count, sp, lo, hi, lc, rc, ei;
  logic signed [31:0] a, b, c, pivot;
  logic [CW-1:0] rd_addr, wr_addr, hi1, mid, sum_half;
  logic [CW:0]   sum;
  logic signed [31:0] wr_data, med;
  logic wr_en;
  logic [CW-1:0] push_hi;
  logic pop_d;

  assign hi1 = hi - CW'(1);
  assign sum = {1'b0, lo} + {1'b0, hi};
  assign sum_half = sum[CW:1];
  assign mid = sum_half;
  assign push_hi = rc + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      A_LO:    rd_addr = lo;
      A_HI1:   rd_addr = hi1;
      A_MID:   rd_addr = mid;
      A_LC:    rd_addr = lc;
      A_RC:    rd_addr = rc;
      A_LO1:   rd_addr = lo + CW'(1);
      A_EMIT:  rd_addr = ei;
      A_LC1:   rd_addr = lc + CW'(1);
      A_RC1:   rd_addr = rc - CW'(1);
      default: rd_addr = lo;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    wr_addr = count;
    wr_data = in_value;
    if (cmd.store_in) begin
      wr_en = (count < MAXC);
    end else if (cmd.wr_lc_b) begin
      wr_addr = lc; wr_data = b;
    end else if (cmd.wr_rc_a) begin
      wr_addr = rc; wr_data = a;
    end else if (cmd.pair_wr_lo) begin
      wr_addr = lo; wr_data = b;
    end else if (cmd.pair_wr_lo1) begin
      wr_addr = lo + CW'(1); wr_data = a;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    if (cmd.rd_en) rdata <= mem[rd_addr[AW-1:0]];
  end

  // Median of three from captured registers.
  always_comb begin
    if ((a <= b && b <= c) || (c <= b && b <= a)) med = b;
    else if ((b <= a && a <= c) || (c <= a && a <= b)) med = a;
    else med = c;
  end

  logic push_en;
  logic [2*CW-1:0] push_data;
  logic [CW-1:0] push_len;
  assign push_len = push_hi - lo;
  always_comb begin
    push_en = 1'b0;
    push_data = {lo, push_hi};
    if (cmd.init_stack) begin
      push_en = (count >= CW'(2));
      push_data = {{CW{1'b0}}, count};
    end else if (cmd.part_end) begin
      push_en = (push_hi > lo) && (push_len >= CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) stk[(cmd.init_stack ? {AW{1'b0}} : sp[AW-1:0])] <= push_data;
    if (cmd.pop) stk_rd <= stk[sp[AW-1:0] - AW'(1)];
  end

  // Range registers are loaded from the popped stack entry after it is registered in stk_rd and pop_d.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; sp <= '0; ei <= '0;
      lo <= '0; hi <= '0; lc <= '0; rc <= '0; pivot <= '0;
      pop_d <= 1'b0;
    end else begin
      pop_d <= cmd.pop;
      if (pop_d) begin
        lo <= stk_rd[2*CW-1:CW];
        hi <= stk_rd[CW-1:0];
      end
      if (cmd.store_in && count < MAXC) count <= count + CW'(1);
      if (cmd.clr_count) count <= '0;
      if (cmd.init_stack) sp <= push_en ? CW'(1) : '0;
      else if (cmd.pop) sp <= sp - CW'(1);
      else if (push_en) sp <= sp + CW'(1);
      if (cmd.set_pivot) begin
        pivot <= med; lc <= lo; rc <= hi1;
      end
      if (cmd.inc_lc || cmd.swap_adv) lc <= lc + CW'(1);
      if (cmd.dec_rc || cmd.swap_adv) rc <= rc - CW'(1);
      if (cmd.part_end) lo <= lc;
      if (cmd.emit_clr) ei <= '0;
      if (cmd.emit_inc) ei <= ei + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) a <= rdata;
    if (cmd.cap_b) b <= rdata;
    if (cmd.cap_c) c <= rdata;
    if (cmd.out_load) out_value <= rdata;
  end

  // The right cursor may step below the range start after an exchange at
  // index zero, so the crossing test compares against rc + 1.
  logic [CW-1:0] rlen;
  assign rlen = hi - lo;
  always_comb begin
    stat.full        = (count >= MAXC);
    stat.count_zero  = (count == '0);
    stat.stack_empty = (sp == '0);
    stat.range_small = (rlen <= CW'(2));
    stat.range_two   = (rlen == CW'(2));
    stat.range_done  = (hi <= lo);
    stat.scan_l_go   = (lc < hi1) && (rdata < pivot);
    stat.scan_r_go   = (rc > lo) && (rdata > pivot);
    stat.cross_ok    = (lc < push_hi);
    stat.pair_swap   = (a > b);
    stat.emit_last   = (ei + CW'(1) == count);
  end

endmodule

FILE: rtl/core/mq3s_ctrl.sv
// Controller state machine of the quicksort block.
// Depends on mq3s_pkg.
module mq3s_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  output logic            out_valid,
  output logic            out_last,
  input  logic            out_stall,
  input  mq3s_pkg::stat_t stat,
  output mq3s_pkg::cmd_t  cmd
);
  import mq3s_pkg::*;

  state_t state, state_next;
  logic ovalid, ovalid_next, olast, olast_next;
  logic in_fire, out_free;

  assign in_stall  = (state != ST_LOAD);
  assign in_fire   = in_valid && (state == ST_LOAD);
  assign out_valid = ovalid;
  assign out_last  = olast;
  assign out_free  = !ovalid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; ovalid <= 1'b0; olast <= 1'b0;
    end else begin
      state <= state_next; ovalid <= ovalid_next; olast <= olast_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (in_fire && in_last) state_next = ST_INIT;
      ST_INIT:     state_next = ST_POP;
      ST_POP:      state_next = stat.stack_empty ? ST_EMIT_RD : ST_POP_W;
      ST_POP_W:    state_next = ST_RANGE;
      ST_RANGE:    state_next = stat.range_small ?
                                (stat.range_two ? ST_PAIR_RD : ST_POP) : ST_RD_LO;
      ST_RD_LO:    state_next = ST_RD_HI;
      ST_RD_HI:    state_next = ST_RD_MID;
      ST_RD_MID:   state_next = ST_PIVOT;
      ST_PIVOT:    state_next = ST_SCAN_L;
      ST_SCAN_L:   state_next = stat.cross_ok ? ST_SCAN_LW : ST_PART_END;
      ST_SCAN_LW:  state_next = stat.scan_l_go ? ST_SCAN_LW : ST_SCAN_R;
      ST_SCAN_R:   state_next = ST_SCAN_RW;
      ST_SCAN_RW:  state_next = stat.scan_r_go ? ST_SCAN_RW :
                                (stat.cross_ok ? ST_SWAP_W : ST_PART_END);
      ST_SWAP_W:   state_next = ST_SWAP_W2;
      ST_SWAP_W2:  state_next = ST_SCAN_L;
      ST_PART_END: state_next = ST_RANGE;
      ST_PAIR_RD:  state_next = ST_PAIR_W;
      ST_PAIR_W:   state_next = ST_PAIR_LO;
      ST_PAIR_LO:  state_next = ST_PAIR_LO1;
      ST_PAIR_LO1: state_next = ST_POP;
      ST_EMIT_RD:  state_next = stat.count_zero ? ST_LOAD : ST_EMIT;
      ST_EMIT:     if (out_free) state_next = stat.emit_last ? ST_LOAD : ST_EMIT_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  // The cycle-by-cycle commands. Reads are registered; rdata is
  // valid in the state after the one that issued rd_en. While a scan keeps
  // moving, the next cursor position is read ahead.
  always_comb begin
    cmd = '0;
    ovalid_next = ovalid && out_stall;
    olast_next = olast;
    unique case (state)
      ST_LOAD: begin
        cmd.store_in = in_fire;
      end
      ST_INIT: cmd.init_stack = 1'b1;
      ST_POP:  begin
        cmd.pop = !stat.stack_empty;
        cmd.emit_clr = stat.stack_empty;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = A_EMIT;
      end
      ST_POP_W: ;
      ST_RANGE: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = A_LO;
        if (stat.range_done) cmd = '0;
      end
      ST_RD_LO: begin
        cmd.cap_a = 1'b1; cmd.rd_en = 1'b1; cmd.rd_sel = A_HI1;
      end
      ST_RD_HI: begin
        cmd.cap_b = 1'b1; cmd.rd_en = 1'b1; cmd.rd_sel = A_MID;
      end
      ST_RD_MID: cmd.cap_c = 1'b1;
      ST_PIVOT:  cmd.set_pivot = 1'b1;
      ST_SCAN_L: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = A_LC;
      end
      ST_SCAN_LW: begin
        cmd.cap_a = 1'b1;
        cmd.rd_en = 1'b1;
        if (stat.scan_l_go) begin
          cmd.inc_lc = 1'b1; cmd.rd_sel = A_LC1;
        end else begin
          cmd.rd_sel = A_RC;
        end
      end
      ST_SCAN_R: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = A_RC;
      end
      ST_SCAN_RW: begin
        cmd.cap_b = 1'b1;
        if (stat.scan_r_go) begin
          cmd.dec_rc = 1'b1; cmd.rd_en = 1'b1; cmd.rd_sel = A_RC1;
        end
      end
      // An exchange uses two writes, ST_SWAP_W then ST_SWAP_W2, on the single
      // write port, and the cursors step past the exchanged pair with the second write.
      ST_SWAP_W:  cmd.wr_lc_b = 1'b1;
      ST_SWAP_W2: begin
        cmd.wr_rc_a = 1'b1; cmd.swap_adv = 1'b1;
      end
      ST_PART_END: cmd.part_end = 1'b1;
      ST_PAIR_RD: begin
        cmd.cap_a = 1'b1; cmd.rd_en = 1'b1; cmd.rd_sel = A_LO1;
      end
      ST_PAIR_W: begin
        cmd.cap_b = 1'b1;
      end
      ST_PAIR_LO:  cmd.pair_wr_lo = stat.pair_swap;
      ST_PAIR_LO1: cmd.pair_wr_lo1 = stat.pair_swap;
      ST_EMIT_RD: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = A_EMIT;
        if (stat.count_zero) cmd.clr_count = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.emit_inc = 1'b1;
          ovalid_next = 1'b1;
          olast_next = stat.emit_last;
          cmd.rd_en = 1'b1;
          cmd.rd_sel = A_EMIT;
          if (stat.emit_last) cmd.clr_count = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/median_of_three_quicksort.sv
// Top level of the median-of-three quicksort block.
// Depends on mq3s_pkg, mq3s_ctrl and mq3s_datapath.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid / in_stall
//   out     | output    | out_item_t | out_valid / out_stall
//
// Loading takes one transfer per cycle. After the closing transfer the block
// sorts in place through one store access a cycle: each scan step reads one
// value, each exchange writes both values and then restarts the scans, each
// partition first reads three pivot candidates, and a range of two is sorted
// by one compare and at most two writes. Results then leave one at a time,
// a read and an emit state each, while out_stall is low; a stalled result
// holds and freezes the emit. Reset (rst, synchronous) clears counts, stack
// pointer and state; the store needs no clearing since only written entries
// are read. in_stall is high from the closing transfer until the last result
// enters the output register.
module median_of_three_quicksort #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mq3s_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mq3s_pkg::out_item_t out_data
);
  import mq3s_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  olast;
  logic signed [31:0] oval;

  // The controller sequences loading, partitioning and emitting; the
  // datapath holds the store, the range stack and the cursors.
  mq3s_ctrl u_ctrl (
    .clk, .rst,
    .in_valid, .in_last(in_data.is_last), .in_stall,
    .out_valid, .out_last(olast), .out_stall,
    .stat, .cmd
  );

  mq3s_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk, .rst,
    .cmd,
    .in_value(in_data.value),
    .stat,
    .out_value(oval)
  );

  assign out_data.sorted_value = oval;
  assign out_data.end_of_set   = olast;

endmodule

FILE: test/tb_top.sv
// Testbench for the median-of-three quicksort block.
// Depends on mq3s_pkg and median_of_three_quicksort; self-checking, no files.
`timescale 1ns / 100ps

module tb_top;
  import mq3s_pkg::*;

  localparam int DEPTH = 64;

  // Scoreboard: collects the values of the open set and, when the closing
  // transfer arrives, sorts them and queues the expected results in order.
  class sort_scoreboard;
    logic signed [31:0] held[$];
    out_item_t sorted_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Note one accepted input transfer. A full store drops the value, but the
    // flag still closes the set.
    function void note_input(in_item_t it);
      logic signed [31:0] tmp;
      out_item_t r;
      int n;
      if (held.size() < DEPTH) held.push_back(it.value);
      if (!it.is_last) return;
      n = held.size();
      // Plain insertion sort: the output order of a sort does not depend on
      // the algorithm, so any correct ascending sort predicts the block.
      for (int i = 1; i < n; i++) begin
        tmp = held[i];
        for (int j = i - 1; j >= 0 && held[j] > tmp; j--) begin
          held[j + 1] = held[j];
          held[j] = tmp;
        end
      end
      for (int k = 0; k < n; k++) begin
        r.sorted_value = held[k];
        r.end_of_set = (k == n - 1);
        sorted_q.push_back(r);
      end
      held.delete();
    endfunction

    task check_result(out_item_t got);
      out_item_t exp_r;
      if (sorted_q.size() == 0) begin
        report($sformatf("result %0d/%0b with no expected result",
                         got.sorted_value, got.end_of_set));
        return;
      end
      exp_r = sorted_q.pop_front();
      if (got.sorted_value !== exp_r.sorted_value)
        report($sformatf("sorted_value %0d, expected %0d",
                         got.sorted_value, exp_r.sorted_value));
      if (got.end_of_set !== exp_r.end_of_set)
        report($sformatf("end_of_set %0b, expected %0b",
                         got.end_of_set, exp_r.end_of_set));
    endtask

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  sort_scoreboard sb = new();
  // While set, neither side idles nor stalls.
  bit steady = 1'b0;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  median_of_three_quicksort #(.MAX_ITEMS(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Random value that favors extremes and small magnitudes, so duplicates
  // and ties with the pivot occur often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until a transfer happens; sometimes idle
  // cycles first. Called and returning at a falling edge. in_stall is stable
  // from the falling edge to the next rising edge, so it is checked there.
  task automatic send_item(logic [31:0] v, logic last);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{value: v, is_last: last};
    #1;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_input(in_data);
    @(negedge clk);
  endtask

  task automatic send_set(int n, int kind);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        1: v = 32'(i);                  // ascending
        2: v = 32'(n - i);              // descending
        3: v = 32'd5;                   // all equal
        4: v = (i % 2) ? 32'h7fff_ffff : 32'h8000_0000;
        default: v = pick_value();
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  // Output side: random stalls, results checked on the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  initial begin
    int sent;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets: single value, pair, extremes, sorted, reversed, equal,
    // and an overfull set whose extra values are dropped.
    send_set(1, 0);
    send_set(2, 2);
    send_set(2, 4);
    send_set(3, 3);
    send_set(5, 1);
    send_set(6, 2);
    send_set(4, 4);
    send_set(70, 0);
    send_set(DEPTH, 2);

    // Random sets, mostly small; a no-idle stretch in the middle.
    sent = 0;
    while (sent < 145) begin
      steady = (sent >= 40 && sent < 100);
      n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 4, 30)
                                   : $urandom_range(12, 1);
      send_set(n, ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0);
      sent += n;
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.sorted_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.sorted_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
